@@ rtl/ibt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ibt_pkg;

  // Width of one time stamp (start or end of an interval).
  localparam int TIME_WIDTH = 31;

  // Result status codes.
  localparam logic [1:0] ST_BOOKED  = 2'd0;
  localparam logic [1:0] ST_OVERLAP = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] start_time;
    logic [TIME_WIDTH-1:0] end_time;
  } in_beat_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] status;
  } out_beat_t;

  // Status of the overlap compare unit toward the sequencer.
  typedef struct packed {
    logic busy;
    logic hit;
  } scan_stat_t;

endpackage

`default_nettype wire

@@ rtl/ibt_slot_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ibt_slot_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 62
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata,
  output logic               rvld
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;
  logic          rvld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  // Flag the registered read data for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r <= 1'b0;
    end else begin
      rvld_r <= re;
    end
  end

  assign rdata = rdata_r;
  assign rvld  = rvld_r;

endmodule

`default_nettype wire

@@ rtl/ibt_overlap_cmp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ibt_overlap_cmp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              clear,
  input  wire logic                              rd_vld,
  input  wire logic [ibt_pkg::TIME_WIDTH-1:0]    slot_start,
  input  wire logic [ibt_pkg::TIME_WIDTH-1:0]    slot_end,
  input  wire logic [ibt_pkg::TIME_WIDTH-1:0]    req_start,
  input  wire logic [ibt_pkg::TIME_WIDTH-1:0]    req_end,
  output ibt_pkg::scan_stat_t                    stat
);

  logic [ibt_pkg::TIME_WIDTH-1:0] lo;
  logic [ibt_pkg::TIME_WIDTH-1:0] hi;
  logic                           meet;
  logic                           hit_r;
  logic                           busy_r;

  // Larger start below smaller end means the intervals share a point.
  always_comb begin
    lo   = (slot_start > req_start) ? slot_start : req_start;
    hi   = (slot_end < req_end) ? slot_end : req_end;
    meet = (lo < hi);
  end

  // Accumulate a sticky hit over the scan; clear it at each new request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      busy_r <= 1'b0;
    end else if (clear) begin
      hit_r  <= 1'b0;
      busy_r <= 1'b0;
    end else begin
      busy_r <= rd_vld;
      if (rd_vld && meet) begin
        hit_r <= 1'b1;
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.hit  = hit_r;

endmodule

`default_nettype wire

@@ rtl/interval_booking_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Overlap-checked reservation table. Each input beat books the half-open
// interval [start_time, end_time). The request is compared, one stored entry
// per cycle, against every interval already booked; if any overlaps, the
// result beat says accepted 0 / status overlap. Otherwise the interval is
// appended and the result is accepted 1 / status booked, unless all
// TABLE_DEPTH slots are used, in which case the table is left alone and the
// result is status full (overlap wins over full). Empty requests (start >=
// end) overlap nothing and are stored. The block handles one request at a
// time: in_stall is high from the accepting edge until the result has been
// loaded into the output register. The scan reads each stored interval in
// turn, the registered read data reaches the compare unit, its hit register
// drains, the scan is left and the result is decided; with an empty table
// there are no reads. The decide step stretches for as long as an earlier
// result still waits in the output register under out_stall. The scan time
// is set by the single read port of the slot memory, which feeds a shared
// compare unit one entry per cycle. The table is empty after reset; no
// clearing pass is needed.
module interval_booking_table #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ibt_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ibt_pkg::out_beat_t      out_data
);

  localparam int TW = ibt_pkg::TIME_WIDTH;
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0]          state_r, state_nxt;
  ibt_pkg::in_beat_t   req_r, req_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  ibt_pkg::out_beat_t  out_data_r, out_data_nxt;

  logic                in_fire;
  logic                out_free;
  logic                scan_rd;
  logic                scan_done;
  logic                decide;
  logic                book;
  logic                full;

  logic [2*TW-1:0]     ram_rdata;
  logic                ram_rvld;
  ibt_pkg::scan_stat_t stat;

  // Slot memory: start in the upper half of a word, end in the lower half.
  ibt_slot_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .DW    (2 * TW)
  ) u_slot_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (book),
    .waddr (count_r[AW-1:0]),
    .wdata ({req_r.start_time, req_r.end_time}),
    .re    (scan_rd),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata),
    .rvld  (ram_rvld)
  );

  // Shared compare unit: one stored interval against the request per cycle.
  ibt_overlap_cmp u_overlap_cmp (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (in_fire),
    .rd_vld     (ram_rvld),
    .slot_start (ram_rdata[2*TW-1:TW]),
    .slot_end   (ram_rdata[TW-1:0]),
    .req_start  (req_r.start_time),
    .req_end    (req_r.end_time),
    .stat       (stat)
  );

  always_comb begin
    in_stall  = (state_r != S_IDLE);
    in_fire   = in_valid && !in_stall;
    out_free  = !out_valid_r || !out_stall;
    // Issue reads until every stored slot has been fetched.
    scan_rd   = (state_r == S_SCAN) && (idx_r != count_r);
    // Scan ends once the last read has drained through the compare unit.
    scan_done = (state_r == S_SCAN) && (idx_r == count_r) && !ram_rvld && !stat.busy;
    // Hold the decision while an earlier result still waits downstream.
    decide    = (state_r == S_DECIDE) && out_free;
    full      = (count_r == DEPTH_C);
    book      = decide && !stat.hit && !full;
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_nxt   = in_data;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_rd) begin
          idx_nxt = idx_r + CW'(1);
        end
        if (scan_done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (decide) begin
          out_valid_nxt = 1'b1;
          if (stat.hit) begin
            out_data_nxt.accepted = 1'b0;
            out_data_nxt.status   = ibt_pkg::ST_OVERLAP;
          end else if (full) begin
            out_data_nxt.accepted = 1'b0;
            out_data_nxt.status   = ibt_pkg::ST_FULL;
          end else begin
            out_data_nxt.accepted = 1'b1;
            out_data_nxt.status   = ibt_pkg::ST_BOOKED;
            count_nxt             = count_r + CW'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Table fill never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("slot count beyond table depth");

  // Accepted flag and status agree on every result beat.
  a_out_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.accepted == (out_data_r.status == ibt_pkg::ST_BOOKED)))
    else $error("accepted flag disagrees with status");

  // A booked slot always comes with a freshly loaded booked result.
  a_count_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |->
      (out_valid_r && out_data_r.accepted && (count_r == $past(count_r) + CW'(1))))
    else $error("slot count moved without a booked result");

  // An accepted request starts a scan on the next cycle.
  a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_SCAN))
    else $error("accepted request did not start a scan");

endmodule

`default_nettype wire
